/* design/c3p_pkg.sv */
// Package for the circle-from-three-points block.
// Holds widths, pipeline depths and the structs that move between the cells.
`default_nettype none
package c3p_pkg;
    localparam int COORD_BITS = 16;
    localparam int OUT_W      = 32;
    localparam int DIF_W      = COORD_BITS + 1;
    localparam int PRD_W      = 2 * DIF_W;
    localparam int DET_W      = PRD_W + 1;
    localparam int DEN_W      = DET_W + 1;
    localparam int SQS_W      = PRD_W + 1;
    localparam int NUM_W      = DIF_W + SQS_W + 3;
    localparam int Q_W        = OUT_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int CMP_W      = DEN_W + Q_W;
    localparam int D_W        = OUT_W + 1;
    localparam int SQ_W       = 2 * D_W;
    localparam int N_W        = SQ_W + 1;
    localparam int RT_W       = (N_W + 1) / 2;
    localparam int S_W        = RT_W + 2;
    localparam int D3_STEP    = 4;
    localparam int D3_CELLS   = (S_W + D3_STEP - 1) / D3_STEP;
    localparam int D3_W       = D3_CELLS * D3_STEP;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord cx;
        t_coord cy;
    } t_pts;

    // Side data that rides along the divider chain.
    typedef struct packed {
        logic vld;
        logic ok;
        t_pts pts;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_div_side;

    // Side data that rides along the square root and divide-by-three chains.
    typedef struct packed {
        logic                    vld;
        logic                    ok;
        logic signed [OUT_W-1:0] ox;
        logic signed [OUT_W-1:0] oy;
    } t_ctr_side;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   num_lo;
        logic [Q_W-1:0]   q;
    } t_div_lane;

    typedef struct packed {
        logic [RT_W+1:0]   rem;
        logic [RT_W-1:0]   root;
        logic [2*RT_W-1:0] n;
    } t_sq_lane;

    typedef struct packed {
        logic [1:0]      rem;
        logic [D3_W-1:0] s;
        logic [D3_W-1:0] q;
    } t_d3_lane;
endpackage
`default_nettype wire

/* design/c3p_ifs.sv */
// Valid/ready channel interfaces for the point triple and the circle result.
// Depends on c3p_pkg.
`default_nettype none
interface c3p_in_if
    import c3p_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord point_a_x;
    t_coord point_a_y;
    t_coord point_b_x;
    t_coord point_b_y;
    t_coord point_c_x;
    t_coord point_c_y;
    modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y,
                    point_c_x, point_c_y, input ready);
    modport sink (input valid, point_a_x, point_a_y, point_b_x, point_b_y,
                  point_c_x, point_c_y, output ready);
endinterface

interface c3p_out_if
    import c3p_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [OUT_W-1:0]        radius;
    logic                    circle_valid;
    modport source (output valid, center_x, center_y, radius, circle_valid, input ready);
    modport sink (input valid, center_x, center_y, radius, circle_valid, output ready);
endinterface
`default_nettype wire

/* design/c3p_div_cell.sv */
// One restoring division step: one quotient bit per cell.
// Depends on c3p_pkg.
`default_nettype none
module c3p_div_cell
    import c3p_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  wire t_div_lane i_lane,
    output t_div_lane      o_lane
);
    logic [DEN_W:0] w_trial;
    logic           w_take;
    t_div_lane      n_lane;
    t_div_lane      r_lane;

    // Shift in the next numerator bit and subtract the divisor if it fits.
    always_comb begin
        w_trial = {i_lane.rem, i_lane.num_lo[Q_W-1]};
        w_take  = w_trial >= {1'b0, i_lane.den};
        n_lane.den    = i_lane.den;
        n_lane.num_lo = i_lane.num_lo << 1;
        n_lane.q      = {i_lane.q[Q_W-2:0], w_take};
        n_lane.rem    = w_take ? DEN_W'(w_trial - {1'b0, i_lane.den}) : DEN_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule
`default_nettype wire

/* design/c3p_sqrt_cell.sv */
// One digit-by-digit integer square root step: one root bit per cell.
// Depends on c3p_pkg.
`default_nettype none
module c3p_sqrt_cell
    import c3p_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  wire t_sq_lane i_lane,
    output t_sq_lane      o_lane
);
    logic [RT_W+3:0] w_part;
    logic [RT_W+3:0] w_trial;
    logic            w_take;
    t_sq_lane        n_lane;
    t_sq_lane        r_lane;

    // Bring down the next bit pair and test root*4+1 against the remainder.
    always_comb begin
        w_part  = {i_lane.rem, i_lane.n[2*RT_W-1 -: 2]};
        w_trial = {2'b00, i_lane.root, 2'b01};
        w_take  = w_part >= w_trial;
        n_lane.n    = i_lane.n << 2;
        n_lane.root = {i_lane.root[RT_W-2:0], w_take};
        n_lane.rem  = w_take ? (RT_W+2)'(w_part - w_trial) : (RT_W+2)'(w_part);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule
`default_nettype wire

/* design/c3p_div3_cell.sv */
// Division by three, a few quotient bits per cell with a two-bit remainder.
// Depends on c3p_pkg.
`default_nettype none
module c3p_div3_cell
    import c3p_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  wire t_d3_lane i_lane,
    output t_d3_lane      o_lane
);
    logic [2:0] w_t;
    t_d3_lane   n_lane;
    t_d3_lane   r_lane;

    // Long division by three over the top bits of the dividend.
    always_comb begin
        n_lane = i_lane;
        w_t    = '0;
        for (int k = 0; k < D3_STEP; k++) begin
            w_t = {n_lane.rem, n_lane.s[D3_W-1]};
            n_lane.s = n_lane.s << 1;
            if (w_t >= 3'd3) begin
                n_lane.rem = 2'(w_t - 3'd3);
                n_lane.q   = {n_lane.q[D3_W-2:0], 1'b1};
            end else begin
                n_lane.rem = 2'(w_t);
                n_lane.q   = {n_lane.q[D3_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule
`default_nettype wire

/* design/circle_from_three_points.sv */
// Circle through three points. The block takes one point triple per cycle while
// not stalled and returns the circumcenter (truncated toward zero, clamped to
// 32 bits) and the truncated mean of the three point-to-center distances. The
// pipeline contains the 32-cell quotient chain, the 34-cell square root chain
// and the nine-cell divide-by-three chain. The whole pipeline advances together
// and holds only while a result waits at the output and is not taken.
// Collinear or coincident points give circle_valid low with all fields zero.
`default_nettype none
module circle_from_three_points
    import c3p_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    c3p_in_if.sink    i_pts,
    c3p_out_if.source o_circ
);
    logic w_en;
    logic r_out_vld;

    assign w_en        = !r_out_vld || o_circ.ready;
    assign i_pts.ready = w_en;

    // Stage 1: differences relative to point A.
    logic r1_vld;
    t_pts r1_pts;
    logic signed [DIF_W-1:0] r1_bx, r1_by, r1_cx, r1_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_pts.valid;
        end
        if (w_en) begin
            r1_pts <= '{i_pts.point_a_x, i_pts.point_a_y, i_pts.point_b_x,
                        i_pts.point_b_y, i_pts.point_c_x, i_pts.point_c_y};
            r1_bx <= DIF_W'(i_pts.point_b_x) - DIF_W'(i_pts.point_a_x);
            r1_by <= DIF_W'(i_pts.point_b_y) - DIF_W'(i_pts.point_a_y);
            r1_cx <= DIF_W'(i_pts.point_c_x) - DIF_W'(i_pts.point_a_x);
            r1_cy <= DIF_W'(i_pts.point_c_y) - DIF_W'(i_pts.point_a_y);
        end
    end

    // Stage 2: cross products and squares.
    logic r2_vld;
    t_pts r2_pts;
    logic signed [DIF_W-1:0] r2_bx, r2_by, r2_cx, r2_cy;
    logic signed [PRD_W-1:0] r2_bxcy, r2_bycx, r2_bxbx, r2_byby, r2_cxcx, r2_cycy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
        if (w_en) begin
            r2_pts  <= r1_pts;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
            r2_bxcy <= r1_bx * r1_cy;
            r2_bycx <= r1_by * r1_cx;
            r2_bxbx <= r1_bx * r1_bx;
            r2_byby <= r1_by * r1_by;
            r2_cxcx <= r1_cx * r1_cx;
            r2_cycy <= r1_cy * r1_cy;
        end
    end

    // Stage 3: determinant, doubled denominator and squared lengths.
    logic r3_vld, r3_ok;
    t_pts r3_pts;
    logic signed [DIF_W-1:0] r3_bx, r3_by, r3_cx, r3_cy;
    logic signed [DEN_W-1:0] r3_den;
    logic [SQS_W-1:0]        r3_sb, r3_sc;
    logic signed [DET_W-1:0] w3_det;

    assign w3_det = DET_W'(r2_bxcy) - DET_W'(r2_bycx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
        if (w_en) begin
            r3_pts <= r2_pts;
            r3_bx  <= r2_bx;
            r3_by  <= r2_by;
            r3_cx  <= r2_cx;
            r3_cy  <= r2_cy;
            r3_ok  <= w3_det != '0;
            r3_den <= {w3_det, 1'b0};
            r3_sb  <= SQS_W'(unsigned'(r2_bxbx)) + SQS_W'(unsigned'(r2_byby));
            r3_sc  <= SQS_W'(unsigned'(r2_cxcx)) + SQS_W'(unsigned'(r2_cycy));
        end
    end

    // Stage 4: numerator products.
    logic r4_vld, r4_ok;
    t_pts r4_pts;
    logic signed [DEN_W-1:0] r4_den;
    logic signed [NUM_W-1:0] r4_axden, r4_ayden, r4_cysb, r4_bysc, r4_bxsc, r4_cxsb;
    logic signed [SQS_W:0]   w4_sb, w4_sc;

    assign w4_sb = $signed({1'b0, r3_sb});
    assign w4_sc = $signed({1'b0, r3_sc});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
        if (w_en) begin
            r4_pts   <= r3_pts;
            r4_ok    <= r3_ok;
            r4_den   <= r3_den;
            r4_axden <= r3_pts.ax * r3_den;
            r4_ayden <= r3_pts.ay * r3_den;
            r4_cysb  <= r3_cy * w4_sb;
            r4_bysc  <= r3_by * w4_sc;
            r4_bxsc  <= r3_bx * w4_sc;
            r4_cxsb  <= r3_cx * w4_sb;
        end
    end

    // Stage 5: numerator sums.
    logic r5_vld, r5_ok;
    t_pts r5_pts;
    logic signed [DEN_W-1:0] r5_den;
    logic signed [NUM_W-1:0] r5_numx, r5_numy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
        if (w_en) begin
            r5_pts  <= r4_pts;
            r5_ok   <= r4_ok;
            r5_den  <= r4_den;
            r5_numx <= r4_axden + r4_cysb - r4_bysc;
            r5_numy <= r4_ayden + r4_bxsc - r4_cxsb;
        end
    end

    // Stage 6: magnitudes and quotient signs.
    logic r6_vld, r6_ok, r6_neg_x, r6_neg_y;
    t_pts r6_pts;
    logic [DEN_W-1:0] r6_dmag;
    logic [NUM_W-1:0] r6_xmag, r6_ymag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= r5_vld;
        end
        if (w_en) begin
            r6_pts   <= r5_pts;
            r6_ok    <= r5_ok;
            r6_neg_x <= r5_numx[NUM_W-1] ^ r5_den[DEN_W-1];
            r6_neg_y <= r5_numy[NUM_W-1] ^ r5_den[DEN_W-1];
            r6_dmag  <= r5_den[DEN_W-1] ? DEN_W'(-r5_den) : DEN_W'(r5_den);
            r6_xmag  <= r5_numx[NUM_W-1] ? NUM_W'(-r5_numx) : NUM_W'(r5_numx);
            r6_ymag  <= r5_numy[NUM_W-1] ? NUM_W'(-r5_numy) : NUM_W'(r5_numy);
        end
    end

    // Quotient chain: overflow test, then one quotient bit per cell.
    logic [CMP_W-1:0] w_dsh;
    t_div_side        w_div_side;
    t_div_side        r_div_side [DIV_STEPS];
    t_div_lane        w_lx [DIV_STEPS+1];
    t_div_lane        w_ly [DIV_STEPS+1];

    assign w_dsh = {r6_dmag, {Q_W{1'b0}}};

    always_comb begin
        w_div_side.vld   = r6_vld;
        w_div_side.ok    = r6_ok;
        w_div_side.pts   = r6_pts;
        w_div_side.neg_x = r6_neg_x;
        w_div_side.neg_y = r6_neg_y;
        w_div_side.ovf_x = CMP_W'(r6_xmag) >= w_dsh;
        w_div_side.ovf_y = CMP_W'(r6_ymag) >= w_dsh;
        w_lx[0] = '{DEN_W'(r6_xmag >> Q_W), r6_dmag, Q_W'(r6_xmag), '0};
        w_ly[0] = '{DEN_W'(r6_ymag >> Q_W), r6_dmag, Q_W'(r6_ymag), '0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_div_side[k] <= '0;
            end
        end else if (w_en) begin
            r_div_side[0] <= w_div_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_div_side[k] <= r_div_side[k-1];
            end
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        c3p_div_cell u_cx (.i_clk(i_clk), .i_en(w_en), .i_lane(w_lx[g]), .o_lane(w_lx[g+1]));
        c3p_div_cell u_cy (.i_clk(i_clk), .i_en(w_en), .i_lane(w_ly[g]), .o_lane(w_ly[g+1]));
    end

    // Clamp the center to 32 bits.
    localparam logic [Q_W-1:0] NEG_LIM = Q_W'(1) << (OUT_W - 1);

    function automatic logic signed [OUT_W-1:0] sat_q(logic neg, logic ovf, logic [Q_W-1:0] q);
        logic signed [OUT_W-1:0] v;
        if (neg) begin
            v = (ovf || q > NEG_LIM) ? OUT_W'(NEG_LIM) : OUT_W'(-q);
        end else begin
            v = (ovf || q[Q_W-1]) ? OUT_W'(NEG_LIM - Q_W'(1)) : OUT_W'(q);
        end
        return v;
    endfunction

    t_div_side w_dend;
    logic r8_vld, r8_ok;
    t_pts r8_pts;
    logic signed [OUT_W-1:0] r8_ox, r8_oy;

    assign w_dend = r_div_side[DIV_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r8_vld <= w_dend.vld;
        end
        if (w_en) begin
            r8_ok  <= w_dend.ok;
            r8_pts <= w_dend.pts;
            r8_ox  <= sat_q(w_dend.neg_x, w_dend.ovf_x, w_lx[DIV_STEPS].q);
            r8_oy  <= sat_q(w_dend.neg_y, w_dend.ovf_y, w_ly[DIV_STEPS].q);
        end
    end

    // Distance stages: absolute offsets, squares, sums.
    function automatic logic [D_W-1:0] abs_d(t_coord p, logic signed [OUT_W-1:0] o);
        logic signed [D_W-1:0] d;
        d = D_W'(p) - D_W'(o);
        return d[D_W-1] ? D_W'(-d) : D_W'(d);
    endfunction

    t_ctr_side r9_side, r10_side, r11_side;
    logic [D_W-1:0]  r9_a [6];
    logic [SQ_W-1:0] r10_s [6];
    logic [N_W-1:0]  r11_n [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_side  <= '0;
            r10_side <= '0;
            r11_side <= '0;
        end else if (w_en) begin
            r9_side  <= '{r8_vld, r8_ok, r8_ox, r8_oy};
            r10_side <= r9_side;
            r11_side <= r10_side;
        end
        if (w_en) begin
            r9_a[0] <= abs_d(r8_pts.ax, r8_ox);
            r9_a[1] <= abs_d(r8_pts.ay, r8_oy);
            r9_a[2] <= abs_d(r8_pts.bx, r8_ox);
            r9_a[3] <= abs_d(r8_pts.by, r8_oy);
            r9_a[4] <= abs_d(r8_pts.cx, r8_ox);
            r9_a[5] <= abs_d(r8_pts.cy, r8_oy);
            for (int k = 0; k < 6; k++) begin
                r10_s[k] <= r9_a[k] * r9_a[k];
            end
            for (int k = 0; k < 3; k++) begin
                r11_n[k] <= N_W'(r10_s[2*k]) + N_W'(r10_s[2*k+1]);
            end
        end
    end

    // Square root chains, one lane per point.
    t_ctr_side r_sq_side [RT_W];
    t_sq_lane  w_sq [3][RT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RT_W; k++) begin
                r_sq_side[k] <= '0;
            end
        end else if (w_en) begin
            r_sq_side[0] <= r11_side;
            for (int k = 1; k < RT_W; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_sq[l][0] = '{'0, '0, (2*RT_W)'(r11_n[l])};
        for (genvar g = 0; g < RT_W; g++) begin : g_sq
            c3p_sqrt_cell u_sq (.i_clk(i_clk), .i_en(w_en), .i_lane(w_sq[l][g]),
                                .o_lane(w_sq[l][g+1]));
        end
    end

    // Sum of the three distances.
    t_ctr_side      r12_side;
    logic [S_W-1:0] r12_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_side <= '0;
        end else if (w_en) begin
            r12_side <= r_sq_side[RT_W-1];
        end
        if (w_en) begin
            r12_sum <= S_W'(w_sq[0][RT_W].root) + S_W'(w_sq[1][RT_W].root)
                     + S_W'(w_sq[2][RT_W].root);
        end
    end

    // Divide-by-three chain.
    t_ctr_side r_d3_side [D3_CELLS];
    t_d3_lane  w_d3 [D3_CELLS+1];

    assign w_d3[0] = '{'0, D3_W'(r12_sum), '0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < D3_CELLS; k++) begin
                r_d3_side[k] <= '0;
            end
        end else if (w_en) begin
            r_d3_side[0] <= r12_side;
            for (int k = 1; k < D3_CELLS; k++) begin
                r_d3_side[k] <= r_d3_side[k-1];
            end
        end
    end

    for (genvar g = 0; g < D3_CELLS; g++) begin : g_d3
        c3p_div3_cell u_d3 (.i_clk(i_clk), .i_en(w_en), .i_lane(w_d3[g]), .o_lane(w_d3[g+1]));
    end

    // Output register; an invalid circle reports zeros.
    t_ctr_side               w_fin;
    logic [D3_W-1:0]         w_q3;
    logic [OUT_W-1:0]        w_rad;
    logic signed [OUT_W-1:0] r_cx, r_cy;
    logic [OUT_W-1:0]        r_rad;
    logic                    r_ok;

    assign w_fin = r_d3_side[D3_CELLS-1];
    assign w_q3  = w_d3[D3_CELLS].q;
    assign w_rad = (w_q3 >> OUT_W) != '0 ? '1 : OUT_W'(w_q3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_fin.vld;
        end
        if (w_en) begin
            r_ok  <= w_fin.ok;
            r_cx  <= w_fin.ok ? w_fin.ox : '0;
            r_cy  <= w_fin.ok ? w_fin.oy : '0;
            r_rad <= w_fin.ok ? w_rad : '0;
        end
    end

    assign o_circ.valid        = r_out_vld;
    assign o_circ.center_x     = r_cx;
    assign o_circ.center_y     = r_cy;
    assign o_circ.radius       = r_rad;
    assign o_circ.circle_valid = r_ok;

    // A held result stalls the whole pipeline, the input side included.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_circ.valid && !o_circ.ready) |-> !i_pts.ready)
        else $error("input taken while result stalled");

    // An invalid circle carries zero fields.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_circ.valid && !o_circ.circle_valid) |->
        (o_circ.radius == '0 && o_circ.center_x == '0 && o_circ.center_y == '0))
        else $error("invalid circle with nonzero fields");

    // No result leaves straight after reset.
    a_rst: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !o_circ.valid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire

/* dv/circle_from_three_points_tb.sv */
// Self-checking testbench for circle_from_three_points.
// Results are predicted from the accepted point triples and checked field by field; needs c3p_pkg and c3p_ifs.
`timescale 1ns / 100ps
`default_nettype none
module circle_from_three_points_tb;
    import c3p_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic [OUT_W-1:0]        rad;
        logic                    ok;
    } t_circle;

    logic i_clk;
    logic i_rst_n;
    c3p_in_if  pts_if();
    c3p_out_if circ_if();

    circle_from_three_points uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pts   (pts_if),
        .o_circ  (circ_if)
    );

    t_pts    pending_pts[$];
    t_circle expected_circles[$];
    int      tx_idle_pct;
    int      rx_idle_pct;
    int      mismatches;

    // Integer square root of a nonnegative value below 2^128.
    function automatic logic [127:0] int_sqrt(logic [127:0] n);
        logic [127:0] root;
        logic [127:0] cand;
        root = 0;
        for (int i = 63; i >= 0; i--) begin
            cand = root | (128'd1 << i);
            if (cand * cand <= n) root = cand;
        end
        return root;
    endfunction

    function automatic logic [127:0] point_dist(logic signed [127:0] px, logic signed [127:0] py,
                                                logic signed [127:0] ox, logic signed [127:0] oy);
        logic signed [127:0] dx;
        logic signed [127:0] dy;
        dx = px - ox;
        dy = py - oy;
        return int_sqrt(dx * dx + dy * dy);
    endfunction

    function automatic logic signed [127:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 128'sd2147483647;
        if (v < -128'sd2147483648) return -128'sd2147483648;
        return v;
    endfunction

    // Circumcenter from bisectors relative to A, mean distance from the clamped center.
    function automatic t_circle circumcircle(t_pts p);
        logic signed [127:0] ax, ay, bx, by, cx, cy, det, den, sb, sc, ox, oy;
        logic [127:0] total;
        t_circle r;
        ax = $signed(p.ax);
        ay = $signed(p.ay);
        bx = $signed(p.bx) - ax;
        by = $signed(p.by) - ay;
        cx = $signed(p.cx) - ax;
        cy = $signed(p.cy) - ay;
        det = bx * cy - by * cx;
        if (det == 0) begin
            r.cx = 0;
            r.cy = 0;
            r.rad = 0;
            r.ok = 1'b0;
            return r;
        end
        den = det + det;
        sb = bx * bx + by * by;
        sc = cx * cx + cy * cy;
        ox = clamp32((ax * den + cy * sb - by * sc) / den);
        oy = clamp32((ay * den + bx * sc - cx * sb) / den);
        total = point_dist(ax, ay, ox, oy)
              + point_dist($signed(p.bx), $signed(p.by), ox, oy)
              + point_dist($signed(p.cx), $signed(p.cy), ox, oy);
        total = total / 3;
        r.cx = ox[OUT_W-1:0];
        r.cy = oy[OUT_W-1:0];
        r.rad = (total > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[OUT_W-1:0];
        r.ok = 1'b1;
        return r;
    endfunction

    function automatic t_pts make_pts(int ax, int ay, int bx, int by, int cx, int cy);
        t_pts p;
        p.ax = ax[15:0];
        p.ay = ay[15:0];
        p.bx = bx[15:0];
        p.by = by[15:0];
        p.cx = cx[15:0];
        p.cy = cy[15:0];
        return p;
    endfunction

    function automatic int rnd_coord();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Random triple: half of them general, the rest tight clusters, collinear, coincident
    // and nearly collinear ones.
    function automatic t_pts random_pts();
        int ax, ay, dx, dy, k, sel;
        ax = rnd_coord();
        ay = rnd_coord();
        sel = $urandom_range(9);
        if (sel < 5) begin
            return make_pts(ax, ay, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        end else if (sel == 5) begin
            return make_pts(ax, ay, ax + $urandom_range(15) - 8, ay + $urandom_range(15) - 8,
                            ax + $urandom_range(15) - 8, ay + $urandom_range(15) - 8);
        end else if (sel == 6) begin
            dx = $urandom_range(200) - 100;
            dy = $urandom_range(200) - 100;
            k = $urandom_range(6) - 3;
            return make_pts(ax, ay, ax + dx, ay + dy, ax + k * dx, ay + k * dy);
        end else if (sel == 7) begin
            return make_pts(ax, ay, ax, ay, rnd_coord(), rnd_coord());
        end else begin
            // Nearly collinear: C at most one step off the midpoint of A-B, often a far center.
            dx = $urandom_range(16000);
            dy = $urandom_range(16000);
            ax = $urandom_range(32767) - 32768;
            ay = $urandom_range(32767) - 32768;
            return make_pts(ax, ay, ax + 2 * dx, ay + 2 * dy, ax + dx + $urandom_range(1),
                            ay + dy + $urandom_range(1) - 1);
        end
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender side: one item per handshake, random gaps between items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pts_if.valid <= 1'b0;
        end else if (!pts_if.valid || pts_if.ready) begin
            if (pending_pts.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                automatic t_pts p = pending_pts.pop_front();
                pts_if.point_a_x <= p.ax;
                pts_if.point_a_y <= p.ay;
                pts_if.point_b_x <= p.bx;
                pts_if.point_b_y <= p.by;
                pts_if.point_c_x <= p.cx;
                pts_if.point_c_y <= p.cy;
                pts_if.valid <= 1'b1;
            end else begin
                pts_if.valid <= 1'b0;
            end
        end
    end

    // Receiver stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            circ_if.ready <= 1'b0;
        end else begin
            circ_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: predict accepted items, check accepted results in order.
    always @(posedge i_clk) begin
        if (i_rst_n && pts_if.valid && pts_if.ready) begin
            expected_circles.push_back(circumcircle({pts_if.point_a_x, pts_if.point_a_y,
                                                    pts_if.point_b_x, pts_if.point_b_y,
                                                    pts_if.point_c_x, pts_if.point_c_y}));
        end
        if (i_rst_n && circ_if.valid && circ_if.ready) begin
            if (expected_circles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: cx=%0d cy=%0d r=%0d ok=%b",
                    circ_if.center_x, circ_if.center_y, circ_if.radius, circ_if.circle_valid);
            end else begin
                automatic t_circle e = expected_circles.pop_front();
                if (circ_if.center_x !== e.cx || circ_if.center_y !== e.cy ||
                    circ_if.radius !== e.rad || circ_if.circle_valid !== e.ok) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp cx=%0d cy=%0d r=%0d ok=%b", e.cx, e.cy, e.rad,
                                 e.ok);
                        $display("          got cx=%0d cy=%0d r=%0d ok=%b", circ_if.center_x,
                                 circ_if.center_y, circ_if.radius, circ_if.circle_valid);
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        mismatches = 0;
        tx_idle_pct = 17;
        rx_idle_pct = 56;
        pts_if.valid = 1'b0;
        pts_if.point_a_x = '0;
        pts_if.point_a_y = '0;
        pts_if.point_b_x = '0;
        pts_if.point_b_y = '0;
        pts_if.point_c_x = '0;
        pts_if.point_c_y = '0;
        circ_if.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items: extremes, degenerate triples and far centers.
        pending_pts.push_back(make_pts(0, 0, 0, 0, 0, 0));
        pending_pts.push_back(make_pts(-32768, -32768, -32768, -32768, -32768, -32768));
        pending_pts.push_back(make_pts(32767, 32767, 32767, 32767, 32767, 32767));
        pending_pts.push_back(make_pts(-32768, -32768, 32767, -32768, -32768, 32767));
        pending_pts.push_back(make_pts(32767, 32767, -32768, 32767, 32767, -32768));
        pending_pts.push_back(make_pts(-32768, -32768, 32767, 32767, 0, 0));
        pending_pts.push_back(make_pts(-32768, 32767, 32767, -32768, -32768, -32768));
        pending_pts.push_back(make_pts(0, 0, 10, 0, 0, 10));
        pending_pts.push_back(make_pts(1, 2, 3, 4, 5, 6));
        pending_pts.push_back(make_pts(5, 5, 5, 5, 9, 1));
        pending_pts.push_back(make_pts(0, 0, 32767, 32766, 32766, 32765));
        pending_pts.push_back(make_pts(0, 0, -32768, -32767, -32767, -32766));
        pending_pts.push_back(make_pts(-32768, -32768, 32767, 32766, 32766, 32764));
        pending_pts.push_back(make_pts(32767, -32768, -32768, 32767, -32767, 32765));
        pending_pts.push_back(make_pts(-1, -1, 1, 1, 1, -1));
        pending_pts.push_back(make_pts(0, 0, 1, 0, 0, 1));
        pending_pts.push_back(make_pts(-32768, 0, 32767, 0, 0, 32767));
        pending_pts.push_back(make_pts(0, -32768, 0, 32767, -32768, 0));
        for (int i = 0; i < 420; i++) pending_pts.push_back(random_pts());

        // Let everything drain before the sender continues.
        wait (pending_pts.size() == 0 && !pts_if.valid && expected_circles.size() == 0);
        tx_idle_pct = 56;
        rx_idle_pct = 17;
        for (int i = 0; i < 430; i++) pending_pts.push_back(random_pts());
        wait (pending_pts.size() == 0 && !pts_if.valid && expected_circles.size() == 0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 430; i++) pending_pts.push_back(random_pts());
        wait (pending_pts.size() == 0 && !pts_if.valid && expected_circles.size() == 0);
        repeat (120) @(posedge i_clk);

        if (mismatches == 0 && expected_circles.size() == 0) begin
            $display("circle_from_three_points_tb: clean");
        end else begin
            $display("circle_from_three_points_tb: errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("circle_from_three_points_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
design/c3p_pkg.sv
design/c3p_ifs.sv
design/c3p_div_cell.sv
design/c3p_sqrt_cell.sv
design/c3p_div3_cell.sv
design/circle_from_three_points.sv
dv/circle_from_three_points_tb.sv
